>>> rtl/fccf_pkg.sv
`timescale 1ns / 1ps
package fccf_pkg;

  localparam int MAX_HALF_SIDE_DEF = 8;

  localparam int HALF_SIDE_W = 4;
  localparam logic [HALF_SIDE_W-1:0] HALF_SIDE_RESET = 4'd4;

  localparam int COORD_W  = 4;
  localparam int ACTION_W = 2;
  localparam int COUNT_W  = 9;
  localparam int STEP_W   = 3;

  localparam logic [STEP_W-1:0] STEP_LAST = 3'd4;

  localparam logic [ACTION_W-1:0] ACT_WRITE  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FILTER = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [COORD_W-1:0]  cell_x;
    logic [COORD_W-1:0]  cell_y;
    logic                cell_free;
  } item_t;

  typedef struct packed {
    logic               read_value;
    logic [COUNT_W-1:0] cleared_count;
  } result_t;

  typedef struct packed {
    logic              clr_free;
    logic              clr_vis;
    logic              accept;
    logic              run_start;
    logic              seed;
    logic [1:0]        seed_idx;
    logic              pop;
    logic              load;
    logic              visit;
    logic [STEP_W-1:0] step;
    logic              finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic                clr_last;
    logic                q_empty;
    logic                out_free;
    logic                half_zero;
    logic [ACTION_W-1:0] in_action;
  } ctrl_status_t;

endpackage

>>> rtl/free_cell_connectivity_filter.sv
`timescale 1ns / 1ps
// Free-cell bitmap of side 2H (H from the half_side register, clamped to MAX_HALF_SIDE)
// with write, read and filter items, one result beat per item. After reset a clearing
// pass zeroes all (2^clog2(2*MAX_HALF_SIDE))^2 bitmap entries (256 by default) before
// the first item is taken. In a filter item with H above zero, a pass clears the
// visited marks, four seeds are queued, then each grid cell is visited through the
// single read port of the bitmap memory, which serves the cell and its three centreward
// neighbours in turn. One item is in work at a time; a new item is taken while the
// previous result beat still waits in the output register.
module free_cell_connectivity_filter #(
  parameter int MAX_HALF_SIDE = fccf_pkg::MAX_HALF_SIDE_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fccf_pkg::HALF_SIDE_W-1:0] cfg_data,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  fccf_pkg::item_t                  item,
  output logic                             result_valid,
  input  logic                             result_stall,
  output fccf_pkg::result_t                result
);

  import fccf_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  fccf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  fccf_dp #(.MAX_HALF_SIDE(MAX_HALF_SIDE)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

>>> rtl/fccf_ram.sv
`timescale 1ns / 1ps
module fccf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/fccf_ctrl.sv
`timescale 1ns / 1ps
module fccf_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  fccf_pkg::ctrl_status_t status,
  output fccf_pkg::ctrl_cmd_t    cmd
);

  import fccf_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_VCLR  = 3'd2;
  localparam logic [2:0] S_SEED  = 3'd3;
  localparam logic [2:0] S_POP   = 3'd4;
  localparam logic [2:0] S_LOAD  = 3'd5;
  localparam logic [2:0] S_VISIT = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic [1:0]        seed_idx;
  logic [1:0]        seed_idx_next;

  assign item_stall = (state != S_IDLE);

  always_comb begin
    cmd           = '0;
    state_next    = state;
    step_next     = '0;
    seed_idx_next = '0;
    cmd.step      = step;
    cmd.seed_idx  = seed_idx;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_free = 1'b1;
        cmd.clr_vis  = 1'b1;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          cmd.accept = 1'b1;
          if (status.in_action == ACT_FILTER) begin
            cmd.run_start = 1'b1;
            state_next    = status.half_zero ? S_DONE : S_VCLR;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_VCLR: begin
        cmd.clr_vis = 1'b1;
        if (status.clr_last) begin
          state_next = S_SEED;
        end
      end
      S_SEED: begin
        cmd.seed      = 1'b1;
        seed_idx_next = seed_idx + 2'd1;
        if (seed_idx == 2'd3) begin
          state_next = S_POP;
        end
      end
      S_POP: begin
        if (status.q_empty) begin
          state_next = S_DONE;
        end else begin
          cmd.pop    = 1'b1;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_VISIT;
      end
      S_VISIT: begin
        cmd.visit = 1'b1;
        step_next = step + STEP_W'(1);
        if (step == STEP_LAST) begin
          step_next = '0;
          if (status.q_empty) begin
            state_next = S_DONE;
          end else begin
            cmd.pop    = 1'b1;
            state_next = S_LOAD;
          end
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      step     <= '0;
      seed_idx <= '0;
    end else begin
      state    <= state_next;
      step     <= step_next;
      seed_idx <= seed_idx_next;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !status.q_empty)
    else $error("queue popped while empty");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> status.out_free)
    else $error("result loaded while output register busy");

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |-> !item_stall)
    else $error("beat taken while busy");

endmodule

>>> rtl/fccf_dp.sv
`timescale 1ns / 1ps
module fccf_dp #(
  parameter int MAX_HALF_SIDE = fccf_pkg::MAX_HALF_SIDE_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fccf_pkg::HALF_SIDE_W-1:0]   cfg_data,
  input  fccf_pkg::item_t                    item,
  input  fccf_pkg::ctrl_cmd_t                cmd,
  output fccf_pkg::ctrl_status_t             status,
  output logic                               result_valid,
  input  logic                               result_stall,
  output fccf_pkg::result_t                  result
);

  import fccf_pkg::*;

  localparam int SPAN   = 2 * MAX_HALF_SIDE;
  localparam int SPAN_W = $clog2(SPAN);
  localparam int ADDR_W = 2 * SPAN_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int PTR_W  = ADDR_W + 1;
  localparam int HALF_W = $clog2(MAX_HALF_SIDE + 1);
  localparam int SIDE_W = HALF_W + 1;
  localparam int HC_W   = (HALF_W > HALF_SIDE_W) ? HALF_W : HALF_SIDE_W;
  localparam int CMP_W  = (SIDE_W > COORD_W) ? SIDE_W : COORD_W;

  logic [HALF_SIDE_W-1:0] half_side;
  logic [HALF_W-1:0]      eff_half;
  logic [SIDE_W-1:0]      side;

  logic                   item_in;
  logic [ADDR_W-1:0]      item_addr;
  logic [ACTION_W-1:0]    act_q;
  logic                   inside_q;

  logic [ADDR_W-1:0]      clr_addr;
  logic [PTR_W-1:0]       head;
  logic [PTR_W-1:0]       tail;
  logic [COUNT_W-1:0]     count;

  logic [SPAN_W-1:0]      cur_x;
  logic [SPAN_W-1:0]      cur_y;
  logic [SIDE_W-1:0]      cx;
  logic [SIDE_W-1:0]      cy;
  logic                   x_lo;
  logic                   y_lo;
  logic [SPAN_W-1:0]      xn;
  logic [SPAN_W-1:0]      yn;
  logic [SPAN_W-1:0]      xo;
  logic [SPAN_W-1:0]      yo;
  logic                   vx;
  logic                   vy;
  logic [SPAN_W-1:0]      hm;
  logic [ADDR_W-1:0]      seed_addr;

  logic                   cell_q;
  logic                   na_q;
  logic                   nb_q;
  logic                   clear_now;

  logic [ADDR_W-1:0]      nbr_addr;
  logic [ADDR_W-1:0]      chk_addr;
  logic [ADDR_W-1:0]      enq_addr;
  logic                   enq_ok;
  logic                   enq;

  logic                   fm_wr_en;
  logic [ADDR_W-1:0]      fm_wr_addr;
  logic                   fm_wr_data;
  logic                   fm_rd_en;
  logic [ADDR_W-1:0]      fm_rd_addr;
  logic                   fm_rd_data;

  logic                   vis_wr_en;
  logic [ADDR_W-1:0]      vis_wr_addr;
  logic                   vis_rd_en;
  logic                   vis_rd_data;

  logic                   q_wr_en;
  logic [ADDR_W-1:0]      q_wr_data;
  logic [ADDR_W-1:0]      q_rd_data;

  assign cfg_ready = 1'b1;

  assign eff_half = (HC_W'(half_side) > HC_W'(MAX_HALF_SIDE)) ? HALF_W'(MAX_HALF_SIDE)
                                                               : HALF_W'(half_side);
  assign side     = {eff_half, 1'b0};

  assign item_in   = (CMP_W'(item.cell_x) < CMP_W'(side)) &&
                     (CMP_W'(item.cell_y) < CMP_W'(side));
  assign item_addr = {SPAN_W'(item.cell_y), SPAN_W'(item.cell_x)};

  // centreward and outward neighbours of the current cell
  assign cx   = SIDE_W'(cur_x);
  assign cy   = SIDE_W'(cur_y);
  assign x_lo = cx < SIDE_W'(eff_half);
  assign y_lo = cy < SIDE_W'(eff_half);
  assign xn   = x_lo ? cur_x + SPAN_W'(1) : cur_x - SPAN_W'(1);
  assign yn   = y_lo ? cur_y + SPAN_W'(1) : cur_y - SPAN_W'(1);
  assign xo   = x_lo ? cur_x - SPAN_W'(1) : cur_x + SPAN_W'(1);
  assign yo   = y_lo ? cur_y - SPAN_W'(1) : cur_y + SPAN_W'(1);
  assign vx   = x_lo ? (cur_x != '0) : ((cx + SIDE_W'(1)) < side);
  assign vy   = y_lo ? (cur_y != '0) : ((cy + SIDE_W'(1)) < side);

  assign hm        = SPAN_W'(eff_half) - SPAN_W'(1);
  assign seed_addr = {hm + SPAN_W'(cmd.seed_idx[0]), hm + SPAN_W'(cmd.seed_idx[1])};

  always_comb begin
    nbr_addr = {cur_y, cur_x};
    chk_addr = {cur_y, xo};
    enq_addr = {cur_y, xo};
    enq_ok   = 1'b0;
    case (cmd.step)
      3'd0: begin
        nbr_addr = {cur_y, cur_x};
        chk_addr = {cur_y, xo};
      end
      3'd1: begin
        nbr_addr = {yn, cur_x};
        chk_addr = {yo, xo};
        enq_addr = {cur_y, xo};
        enq_ok   = vx;
      end
      3'd2: begin
        nbr_addr = {yn, xn};
        chk_addr = {yo, cur_x};
        enq_addr = {yo, xo};
        enq_ok   = vx & vy;
      end
      3'd3: begin
        nbr_addr = {cur_y, xn};
        enq_addr = {yo, cur_x};
        enq_ok   = vy;
      end
      default: begin
        enq_ok = 1'b0;
      end
    endcase
  end

  assign enq       = cmd.visit & enq_ok & ~vis_rd_data;
  assign clear_now = cmd.visit && (cmd.step == STEP_LAST) &&
                     cell_q && !na_q && !nb_q && !fm_rd_data;

  // free-cell bitmap
  assign fm_wr_en   = cmd.clr_free | (cmd.accept & (item.action == ACT_WRITE) & item_in) |
                      clear_now;
  assign fm_wr_addr = cmd.clr_free ? clr_addr : (cmd.accept ? item_addr : {cur_y, cur_x});
  assign fm_wr_data = cmd.accept & item.cell_free;
  assign fm_rd_en   = cmd.accept | (cmd.visit & (cmd.step < STEP_W'(3)))
                      | (cmd.visit & (cmd.step == STEP_W'(3)));
  assign fm_rd_addr = cmd.accept ? item_addr : nbr_addr;

  fccf_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_free_map (
    .clk     (clk),
    .wr_en   (fm_wr_en),
    .wr_addr (fm_wr_addr),
    .wr_data (fm_wr_data),
    .rd_en   (fm_rd_en),
    .rd_addr (fm_rd_addr),
    .rd_data (fm_rd_data)
  );

  // visited marks, set when a cell is queued
  assign vis_wr_en   = cmd.clr_vis | cmd.seed | enq;
  assign vis_wr_addr = cmd.clr_vis ? clr_addr : (cmd.seed ? seed_addr : enq_addr);
  assign vis_rd_en   = cmd.visit & (cmd.step < STEP_W'(3));

  fccf_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_visited (
    .clk     (clk),
    .wr_en   (vis_wr_en),
    .wr_addr (vis_wr_addr),
    .wr_data (~cmd.clr_vis),
    .rd_en   (vis_rd_en),
    .rd_addr (chk_addr),
    .rd_data (vis_rd_data)
  );

  // visit queue
  assign q_wr_en   = cmd.seed | enq;
  assign q_wr_data = cmd.seed ? seed_addr : enq_addr;

  fccf_ram #(.WIDTH(ADDR_W), .DEPTH(DEPTH)) u_queue (
    .clk     (clk),
    .wr_en   (q_wr_en),
    .wr_addr (tail[ADDR_W-1:0]),
    .wr_data (q_wr_data),
    .rd_en   (cmd.pop),
    .rd_addr (head[ADDR_W-1:0]),
    .rd_data (q_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      half_side    <= HALF_SIDE_RESET;
      clr_addr     <= '0;
      head         <= '0;
      tail         <= '0;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        half_side <= cfg_data;
      end
      if (cmd.clr_free || cmd.clr_vis) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (cmd.run_start) begin
        head  <= '0;
        tail  <= '0;
        count <= '0;
      end else begin
        if (q_wr_en) begin
          tail <= tail + PTR_W'(1);
        end
        if (cmd.pop) begin
          head <= head + PTR_W'(1);
        end
        if (clear_now) begin
          count <= count + COUNT_W'(1);
        end
      end
      if (cmd.finish) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_q    <= item.action;
      inside_q <= item_in;
    end
    if (cmd.load) begin
      cur_x <= q_rd_data[SPAN_W-1:0];
      cur_y <= q_rd_data[ADDR_W-1:SPAN_W];
    end
    if (cmd.visit) begin
      case (cmd.step)
        3'd1:    cell_q <= fm_rd_data;
        3'd2:    na_q   <= fm_rd_data;
        3'd3:    nb_q   <= fm_rd_data;
        default: cell_q <= cell_q;
      endcase
    end
    if (cmd.finish) begin
      result.read_value    <= (act_q == ACT_READ) & inside_q & fm_rd_data;
      result.cleared_count <= (act_q == ACT_FILTER) ? count : '0;
    end
  end

  assign status.clr_last  = &clr_addr;
  assign status.q_empty   = (head == tail);
  assign status.out_free  = ~result_valid | ~result_stall;
  assign status.half_zero = (eff_half == '0);
  assign status.in_action = item.action;

  a_head_le_tail: assert property (@(posedge clk) disable iff (rst)
    head <= tail)
    else $error("queue head passed tail");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    q_wr_en |-> (tail < PTR_W'(DEPTH)))
    else $error("queue overflow");

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> result_valid)
    else $error("finished result not presented");

endmodule
